/* rtl/priority_dispatch_with_credit_limit_defines.svh */
// ----------------------------------------------------------------------------
// priority_dispatch_with_credit_limit_defines
// assertion macros shared by the dispatcher rtl
// ----------------------------------------------------------------------------
`ifndef PRIORITY_DISPATCH_WITH_CREDIT_LIMIT_DEFINES_SVH
`define PRIORITY_DISPATCH_WITH_CREDIT_LIMIT_DEFINES_SVH

`ifndef SYNTHESIS
`define PDCL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define PDCL_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define PDCL_ASSERT(label, prop, msg)
`define PDCL_ASSERT_NEVER(label, cond, msg)
`endif

`endif

/* rtl/pdcl_pkg.sv */
// ----------------------------------------------------------------------------
// pdcl_pkg
// types, constants and the ordering function of the priority dispatcher
// ----------------------------------------------------------------------------
`default_nettype none

package pdcl_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned WORKERS_DEF     = 4;
  localparam int unsigned MAX_OUT         = 4;
  localparam int unsigned N_W             = 2;
  localparam int unsigned LIM_W           = 5;
  localparam int unsigned MC_W            = 4;
  localparam logic [MC_W-1:0] MC_RESET    = 4'd4;

  typedef enum logic [1:0] {
    KIND_ENQ   = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_FLUSH = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [31:0] gen;
    logic [15:0] weight;
    logic [15:0] tag;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } chain_ctl_t;

  // a is served strictly before b
  function automatic logic beats(entry_t a, entry_t b);
    if (a.weight != b.weight) begin
      return a.weight > b.weight;
    end
    return a.gen < b.gen;
  endfunction

endpackage

`default_nettype wire

/* rtl/pdcl_cell.sv */
// ----------------------------------------------------------------------------
// pdcl_cell
// one slot of the sorted request chain
// ----------------------------------------------------------------------------
`default_nettype none

module pdcl_cell (
  input  wire logic                  clk_i,
  input  wire pdcl_pkg::chain_ctl_t  ctl_i,
  input  wire logic                  occ_i,
  input  wire pdcl_pkg::entry_t      new_i,
  input  wire pdcl_pkg::entry_t      left_i,
  input  wire logic                  left_shift_i,
  input  wire pdcl_pkg::entry_t      right_i,
  output logic                       shift_o,
  output pdcl_pkg::entry_t           entry_o
);
  import pdcl_pkg::*;

  entry_t entry_q, entry_d;

  assign shift_o = !occ_i || beats(new_i, entry_q);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins && shift_o) begin
      entry_d = left_shift_i ? left_i : new_i;
    end else if (ctl_i.pop) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

/* rtl/pdcl_chain.sv */
// ----------------------------------------------------------------------------
// pdcl_chain
// row of cells kept sorted by priority, head at cell zero
// ----------------------------------------------------------------------------
`default_nettype none

module pdcl_chain #(
  parameter int unsigned QUEUE_DEPTH = pdcl_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire pdcl_pkg::chain_ctl_t             ctl_i,
  input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0] count_i,
  input  wire pdcl_pkg::entry_t                 new_i,
  output pdcl_pkg::entry_t                      head_o
);
  import pdcl_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t                 ent [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] shift;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_s;

    if (i == 0) begin : g_first
      assign left_e = new_i;
      assign left_s = 1'b0;
    end else begin : g_mid
      assign left_e = ent[i-1];
      assign left_s = shift[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_e = ent[i];
    end else begin : g_inner
      assign right_e = ent[i+1];
    end

    pdcl_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl_i),
      .occ_i        (count_i > CNT_W'(i)),
      .new_i        (new_i),
      .left_i       (left_e),
      .left_shift_i (left_s),
      .right_i      (right_e),
      .shift_o      (shift[i]),
      .entry_o      (ent[i])
    );
  end

  assign head_o = ent[0];

endmodule

`default_nettype wire

/* rtl/priority_dispatch_with_credit_limit.sv */
// ----------------------------------------------------------------------------
// priority_dispatch_with_credit_limit
// accept moves to dispatch, then one result beat per cycle: 1 to 4 beats
// an insert into the cell chain is registered
// async active-low reset: empty queue, none in flight, no dataset, limit 4
// ----------------------------------------------------------------------------
`default_nettype none

`include "priority_dispatch_with_credit_limit_defines.svh"

module priority_dispatch_with_credit_limit #(
  parameter int unsigned QUEUE_DEPTH = pdcl_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned WORKERS     = pdcl_pkg::WORKERS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [3:0]                       cfg_wdata_i,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [1:0]                       kind_i,
  input  wire logic [15:0]                      node_tag_i,
  input  wire logic [15:0]                      weight_i,
  input  wire logic [31:0]                      generation_i,
  input  wire logic                             dataset_present_i,
  output logic                                  result_valid_o,
  output logic                                  dispatch_valid_o,
  output logic [15:0]                           out_tag_o,
  output logic [15:0]                           out_weight_o,
  output logic [31:0]                           out_generation_o,
  output logic                                  dropped_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]      queued_count_o,
  output logic [$clog2(WORKERS+1)-1:0]          in_flight_o,
  output logic                                  last_o
);
  import pdcl_pkg::*;

  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned LOAD_W = $clog2(WORKERS + 1);

  typedef enum logic {
    ST_IDLE,
    ST_DISP
  } state_e;

  state_e            state_q;
  logic [MC_W-1:0]   mc_q;
  logic [CNT_W-1:0]  count_q;
  logic [LOAD_W-1:0] load_q;
  logic              has_ds_q;
  logic              drop_q;
  logic [N_W-1:0]    n_q;

  logic              res_valid_q, disp_valid_q, dropped_q, last_q;
  logic [15:0]       tag_q, weight_q;
  logic [31:0]       gen_q;
  logic [CNT_W-1:0]  queued_q;
  logic [LOAD_W-1:0] flight_q;

  logic [LIM_W-1:0]  lim;
  logic              accept, drop_now, can_disp, more;
  kind_e             kind;
  chain_ctl_t        ctl;
  entry_t            new_e, head;

  assign kind   = kind_e'(kind_i);
  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    lim = (mc_q == '0) ? LIM_W'(1) : LIM_W'(mc_q);
    if (lim > LIM_W'(WORKERS)) begin
      lim = LIM_W'(WORKERS);
    end
  end

  assign drop_now = (kind == KIND_ENQ) && (!has_ds_q || count_q == CNT_W'(QUEUE_DEPTH));
  assign can_disp = has_ds_q && (count_q != '0) && (LIM_W'(load_q) < lim);
  assign more     = (n_q != N_W'(MAX_OUT - 1)) && (count_q != CNT_W'(1))
                    && ((LIM_W'(load_q) + LIM_W'(1)) < lim);

  assign ctl.ins = accept && (kind == KIND_ENQ) && !drop_now;
  assign ctl.pop = (state_q == ST_DISP) && can_disp;

  assign new_e.tag    = node_tag_i;
  assign new_e.weight = weight_i;
  assign new_e.gen    = generation_i;

  pdcl_chain #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_chain (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .count_i (count_q),
    .new_i   (new_e),
    .head_o  (head)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      mc_q         <= MC_RESET;
      count_q      <= '0;
      load_q       <= '0;
      has_ds_q     <= 1'b0;
      drop_q       <= 1'b0;
      n_q          <= '0;
      res_valid_q  <= 1'b0;
      disp_valid_q <= 1'b0;
      dropped_q    <= 1'b0;
      last_q       <= 1'b0;
      tag_q        <= '0;
      weight_q     <= '0;
      gen_q        <= '0;
      queued_q     <= '0;
      flight_q     <= '0;
    end else begin
      res_valid_q <= (state_q == ST_DISP);
      if (cfg_we_i) begin
        mc_q <= cfg_wdata_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            drop_q  <= drop_now;
            n_q     <= '0;
            state_q <= ST_DISP;
            unique case (kind)
              KIND_ENQ: begin
                if (!drop_now) begin
                  count_q <= count_q + CNT_W'(1);
                end
              end
              KIND_DONE: begin
                if (load_q != '0) begin
                  load_q <= load_q - LOAD_W'(1);
                end
              end
              KIND_FLUSH: begin
                has_ds_q <= dataset_present_i;
                count_q  <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_DISP: begin
          if (can_disp) begin
            disp_valid_q <= 1'b1;
            tag_q        <= head.tag;
            weight_q     <= head.weight;
            gen_q        <= head.gen;
            dropped_q    <= drop_q && (n_q == '0);
            count_q      <= count_q - CNT_W'(1);
            load_q       <= load_q + LOAD_W'(1);
            queued_q     <= count_q - CNT_W'(1);
            flight_q     <= load_q + LOAD_W'(1);
            last_q       <= !more;
            n_q          <= n_q + N_W'(1);
            if (!more) begin
              state_q <= ST_IDLE;
            end
          end else begin
            // nothing to hand out: one status beat
            disp_valid_q <= 1'b0;
            tag_q        <= '0;
            weight_q     <= '0;
            gen_q        <= '0;
            dropped_q    <= drop_q;
            queued_q     <= count_q;
            flight_q     <= load_q;
            last_q       <= 1'b1;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign result_valid_o   = res_valid_q;
  assign dispatch_valid_o = disp_valid_q;
  assign out_tag_o        = tag_q;
  assign out_weight_o     = weight_q;
  assign out_generation_o = gen_q;
  assign dropped_o        = dropped_q;
  assign queued_count_o   = queued_q;
  assign in_flight_o      = flight_q;
  assign last_o           = last_q;

  `PDCL_ASSERT_NEVER(a_load_bound, load_q > LOAD_W'(WORKERS), "in flight above worker count")
  `PDCL_ASSERT_NEVER(a_count_bound, count_q > CNT_W'(QUEUE_DEPTH), "queue count above depth")
  `PDCL_ASSERT(a_last_ends, result_valid_o && last_o |-> !busy, "busy after last beat")
  `PDCL_ASSERT(a_accept_busy, accept |=> busy, "accepted item did not start")
  `PDCL_ASSERT(a_disp_flight, result_valid_o && dispatch_valid_o |-> in_flight_o != '0, "dispatch without load in flight")

endmodule

`default_nettype wire

/* bench/tb_priority_dispatch_with_credit_limit.sv */
// ----------------------------------------------------------------------------
// tb_priority_dispatch_with_credit_limit
// Drives enqueue, completion and dataset commands into the priority
// dispatcher. A directed table comes first, then random phases under
// several credit limits. Every beat is checked field by field against a
// typed table row or a model of the sorted queue and in-flight count.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_priority_dispatch_with_credit_limit;

  import pdcl_pkg::*;

  localparam int unsigned LIMIT_CYCLES  = 200000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASES        = 10;
  localparam int unsigned PHASE_ITEMS   = 30;

  typedef struct packed {
    logic        disp;
    logic [15:0] tag;
    logic [15:0] weight;
    logic [31:0] gen;
    logic        drop;
    logic [4:0]  qcnt;
    logic [2:0]  fl;
    logic        last;
  } beat_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] tag;
    logic [15:0] weight;
    logic [31:0] gen;
    logic        ds;
    logic        typed;
    beat_t       res;
  } stim_row_t;

  localparam stim_row_t DIR_ROWS [22] = '{
    '{KIND_ENQ,   16'h1234, 16'h0010, 32'h0000_0005, 1'b0, 1'b1,
      '{1'b0, 16'h0, 16'h0, 32'h0, 1'b1, 5'd0, 3'd0, 1'b1}},
    '{KIND_DONE,  16'h0, 16'h0, 32'h0, 1'b0, 1'b1,
      '{1'b0, 16'h0, 16'h0, 32'h0, 1'b0, 5'd0, 3'd0, 1'b1}},
    '{KIND_NONE,  16'h0, 16'h0, 32'h0, 1'b0, 1'b1,
      '{1'b0, 16'h0, 16'h0, 32'h0, 1'b0, 5'd0, 3'd0, 1'b1}},
    '{KIND_FLUSH, 16'h0, 16'h0, 32'h0, 1'b0, 1'b1,
      '{1'b0, 16'h0, 16'h0, 32'h0, 1'b0, 5'd0, 3'd0, 1'b1}},
    '{KIND_FLUSH, 16'h0, 16'h0, 32'h0, 1'b1, 1'b1,
      '{1'b0, 16'h0, 16'h0, 32'h0, 1'b0, 5'd0, 3'd0, 1'b1}},
    '{KIND_ENQ,   16'hffff, 16'hffff, 32'hffff_ffff, 1'b1, 1'b1,
      '{1'b1, 16'hffff, 16'hffff, 32'hffff_ffff, 1'b0, 5'd0, 3'd1, 1'b1}},
    '{KIND_ENQ,   16'h0000, 16'h0000, 32'h0000_0000, 1'b0, 1'b1,
      '{1'b1, 16'h0, 16'h0, 32'h0, 1'b0, 5'd0, 3'd2, 1'b1}},
    '{KIND_ENQ,   16'h0001, 16'h8000, 32'h8000_0000, 1'b1, 1'b0, '0},
    '{KIND_ENQ,   16'h0002, 16'h7fff, 32'h7fff_ffff, 1'b0, 1'b0, '0},
    '{KIND_ENQ,   16'h0010, 16'h0005, 32'h0000_000a, 1'b1, 1'b0, '0},
    '{KIND_ENQ,   16'h0011, 16'h0005, 32'h0000_0003, 1'b1, 1'b0, '0},
    '{KIND_ENQ,   16'h0012, 16'h0005, 32'h0000_0003, 1'b0, 1'b0, '0},
    '{KIND_ENQ,   16'h0013, 16'h0009, 32'hffff_ffff, 1'b1, 1'b0, '0},
    '{KIND_DONE,  16'h5555, 16'haaaa, 32'h5555_aaaa, 1'b1, 1'b0, '0},
    '{KIND_DONE,  16'haaaa, 16'h5555, 32'haaaa_5555, 1'b0, 1'b0, '0},
    '{KIND_NONE,  16'h0, 16'h0, 32'h0, 1'b1, 1'b0, '0},
    '{KIND_DONE,  16'h0, 16'h0, 32'h0, 1'b0, 1'b0, '0},
    '{KIND_FLUSH, 16'h0, 16'h0, 32'h0, 1'b0, 1'b0, '0},
    '{KIND_ENQ,   16'h0020, 16'h0001, 32'h0000_0001, 1'b1, 1'b1,
      '{1'b0, 16'h0, 16'h0, 32'h0, 1'b1, 5'd0, 3'd4, 1'b1}},
    '{KIND_DONE,  16'h0, 16'h0, 32'h0, 1'b0, 1'b0, '0},
    '{KIND_FLUSH, 16'h0, 16'h0, 32'h0, 1'b1, 1'b0, '0},
    '{KIND_DONE,  16'h0, 16'h0, 32'h0, 1'b0, 1'b0, '0}
  };

  localparam logic [3:0] LIMIT_PLAN [6] = '{4'd1, 4'd15, 4'd0, 4'd3, 4'd2, 4'd4};

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [3:0]  cfg_wdata_i;
  logic        start;
  logic        busy;
  logic [1:0]  kind_i;
  logic [15:0] node_tag_i;
  logic [15:0] weight_i;
  logic [31:0] generation_i;
  logic        dataset_present_i;
  logic        result_valid_o;
  logic        dispatch_valid_o;
  logic [15:0] out_tag_o;
  logic [15:0] out_weight_o;
  logic [31:0] out_generation_o;
  logic        dropped_o;
  logic [4:0]  queued_count_o;
  logic [2:0]  in_flight_o;
  logic        last_o;

  entry_t      pending_q [$];
  beat_t       expected_beats [$];
  int          in_flight_cnt = 0;
  logic        dataset_on    = 1'b0;
  logic [3:0]  credit_limit  = MC_RESET;
  int          mismatch_cnt  = 0;
  int unsigned cycle_cnt     = 0;

  priority_dispatch_with_credit_limit uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .start             (start),
    .busy              (busy),
    .kind_i            (kind_i),
    .node_tag_i        (node_tag_i),
    .weight_i          (weight_i),
    .generation_i      (generation_i),
    .dataset_present_i (dataset_present_i),
    .result_valid_o    (result_valid_o),
    .dispatch_valid_o  (dispatch_valid_o),
    .out_tag_o         (out_tag_o),
    .out_weight_o      (out_weight_o),
    .out_generation_o  (out_generation_o),
    .dropped_o         (dropped_o),
    .queued_count_o    (queued_count_o),
    .in_flight_o       (in_flight_o),
    .last_o            (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic outranks(entry_t a, entry_t b);
    if (a.weight != b.weight) begin
      return a.weight > b.weight;
    end
    return a.gen < b.gen;
  endfunction

  task automatic predict_dispatches(input kind_e k, input entry_t req, input logic ds,
                                    output beat_t outs [MAX_OUT], output int n);
    int     pos;
    int     lim;
    logic   drop;
    entry_t head;
    drop = 1'b0;
    n = 0;
    case (k)
      KIND_ENQ: begin
        if (!dataset_on || pending_q.size() >= QUEUE_DEPTH_DEF) begin
          drop = 1'b1;
        end else begin
          pos = 0;
          while (pos < pending_q.size() && !outranks(req, pending_q[pos])) pos++;
          pending_q.insert(pos, req);
        end
      end
      KIND_DONE: begin
        if (in_flight_cnt > 0) in_flight_cnt--;
      end
      KIND_FLUSH: begin
        dataset_on = ds;
        pending_q.delete();
      end
      default: begin
      end
    endcase
    lim = (credit_limit == 0) ? 1 : int'(credit_limit);
    if (lim > WORKERS_DEF) lim = WORKERS_DEF;
    while (n < MAX_OUT && dataset_on && pending_q.size() > 0 && in_flight_cnt < lim) begin
      head = pending_q.pop_front();
      in_flight_cnt++;
      outs[n]        = '0;
      outs[n].disp   = 1'b1;
      outs[n].tag    = head.tag;
      outs[n].weight = head.weight;
      outs[n].gen    = head.gen;
      outs[n].drop   = drop && (n == 0);
      outs[n].qcnt   = 5'(pending_q.size());
      outs[n].fl     = 3'(in_flight_cnt);
      n++;
    end
    if (n == 0) begin
      outs[0]      = '0;
      outs[0].drop = drop;
      outs[0].qcnt = 5'(pending_q.size());
      outs[0].fl   = 3'(in_flight_cnt);
      outs[0].last = 1'b1;
      n = 1;
    end else begin
      outs[n-1].last = 1'b1;
    end
  endtask

  task automatic send_item(input kind_e k, input entry_t req, input logic ds, input int gap,
                           input logic typed, input beat_t typed_beat);
    beat_t outs [MAX_OUT];
    int    n;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start             <= 1'b1;
    kind_i            <= k;
    node_tag_i        <= req.tag;
    weight_i          <= req.weight;
    generation_i      <= req.gen;
    dataset_present_i <= ds;
    do @(posedge clk_i); while (busy);
    predict_dispatches(k, req, ds, outs, n);
    if (typed) begin
      expected_beats.insert(expected_beats.size(), typed_beat);
    end else begin
      for (int b = 0; b < n; b++) expected_beats.insert(expected_beats.size(), outs[b]);
    end
  endtask

  task automatic settle_block();
    start <= 1'b0;
    do @(posedge clk_i); while (expected_beats.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_cnt < 40) begin
      $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_cnt);
    end
    mismatch_cnt++;
  endtask

  always @(posedge clk_i) begin : check_beats
    beat_t got;
    beat_t want;
    if (rst_ni && result_valid_o) begin
      got = {dispatch_valid_o, out_tag_o, out_weight_o, out_generation_o,
             dropped_o, queued_count_o, in_flight_o, last_o};
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected beat, tag", 32'(got.tag), 32'h0);
      end else begin
        want = expected_beats.pop_front();
        if (got.disp !== want.disp) report_mismatch("dispatch_valid", 32'(got.disp), 32'(want.disp));
        if (got.tag !== want.tag) report_mismatch("out_tag", 32'(got.tag), 32'(want.tag));
        if (got.weight !== want.weight) begin
          report_mismatch("out_weight", 32'(got.weight), 32'(want.weight));
        end
        if (got.gen !== want.gen) report_mismatch("out_generation", got.gen, want.gen);
        if (got.drop !== want.drop) report_mismatch("dropped", 32'(got.drop), 32'(want.drop));
        if (got.qcnt !== want.qcnt) report_mismatch("queued_count", 32'(got.qcnt), 32'(want.qcnt));
        if (got.fl !== want.fl) report_mismatch("in_flight", 32'(got.fl), 32'(want.fl));
        if (got.last !== want.last) report_mismatch("last", 32'(got.last), 32'(want.last));
      end
    end
  end

  initial begin
    int     r;
    int     gap;
    int     pace;
    logic   fill;
    kind_e  k;
    entry_t req;
    logic   ds;
    logic [3:0] limit_val;
    rst_ni            <= 1'b0;
    start             <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_wdata_i       <= 4'd0;
    kind_i            <= KIND_NONE;
    node_tag_i        <= 16'h0;
    weight_i          <= 16'h0;
    generation_i      <= 32'h0;
    dataset_present_i <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIR_ROWS[j]) begin
      req.tag    = DIR_ROWS[j].tag;
      req.weight = DIR_ROWS[j].weight;
      req.gen    = DIR_ROWS[j].gen;
      send_item(DIR_ROWS[j].kind, req, DIR_ROWS[j].ds, $urandom_range(0, 18),
                DIR_ROWS[j].typed, DIR_ROWS[j].res);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle_block();
      limit_val = (ph < 6) ? LIMIT_PLAN[ph] : 4'($urandom_range(0, 15));
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= limit_val;
      @(posedge clk_i);
      cfg_we_i     <= 1'b0;
      credit_limit  = limit_val;
      fill = (ph == 0 || ph == 2) ? 1'b1 : ($urandom_range(0, 3) == 0);
      pace = $urandom_range(0, 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r          = $urandom_range(0, 99);
        req.tag    = 16'($urandom);
        req.weight = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
        req.gen    = ($urandom_range(0, 2) == 0) ? $urandom : 32'($urandom_range(0, 3));
        ds         = ($urandom_range(0, 3) != 0);
        if (i == 0) begin
          k = KIND_ENQ;
        end else if (!dataset_on && r < 80) begin
          k  = KIND_FLUSH;
          ds = 1'b1;
        end else if (fill) begin
          k = (r < 88) ? KIND_ENQ : (r < 94) ? KIND_DONE : KIND_NONE;
        end else begin
          k = (r < 55) ? KIND_ENQ : (r < 85) ? KIND_DONE : (r < 92) ? KIND_FLUSH : KIND_NONE;
        end
        gap = (pace == 0) ? 0 : (pace == 1) ? $urandom_range(0, 3) : $urandom_range(0, 18);
        if ($urandom_range(0, 39) == 0) settle_block();
        send_item(k, req, ds, gap, 1'b0, '0);
      end
    end

    settle_block();
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
